### sv/c6502_pkg.sv
`timescale 1ns / 1ps
package c6502_pkg;

  typedef enum logic [5:0] {
    OP_LDA = 6'd0, OP_LDX = 6'd1, OP_LDY = 6'd2, OP_STA = 6'd3, OP_STX = 6'd4,
    OP_STY = 6'd5, OP_TAX = 6'd6, OP_TAY = 6'd7, OP_TXA = 6'd8, OP_TYA = 6'd9,
    OP_TSX = 6'd10, OP_TXS = 6'd11, OP_PHA = 6'd12, OP_PHP = 6'd13, OP_PLA = 6'd14,
    OP_PLP = 6'd15, OP_AND = 6'd16, OP_EOR = 6'd17, OP_ORA = 6'd18, OP_BIT = 6'd19,
    OP_ADC = 6'd20, OP_SBC = 6'd21, OP_CMP = 6'd22, OP_CPX = 6'd23, OP_CPY = 6'd24,
    OP_INC = 6'd25, OP_INX = 6'd26, OP_INY = 6'd27, OP_DEC = 6'd28, OP_DEX = 6'd29,
    OP_DEY = 6'd30, OP_ASL = 6'd31, OP_LSR = 6'd32, OP_ROL = 6'd33, OP_ROR = 6'd34,
    OP_JMP = 6'd35, OP_BCC = 6'd36, OP_BCS = 6'd37, OP_BEQ = 6'd38, OP_BMI = 6'd39,
    OP_BNE = 6'd40, OP_BPL = 6'd41, OP_BVC = 6'd42, OP_BVS = 6'd43, OP_CLC = 6'd44,
    OP_CLD = 6'd45, OP_CLI = 6'd46, OP_CLV = 6'd47, OP_SEC = 6'd48, OP_SED = 6'd49,
    OP_SEI = 6'd50, OP_NOP = 6'd51
  } op_e;

  localparam logic [7:0] ResetSp = 8'hFF;
  localparam logic [7:0] ResetP = 8'b0110_0000;
  localparam logic [7:0] StackPage = 8'h01;
  localparam int FlC = 0;
  localparam int FlZ = 1;
  localparam int FlI = 2;
  localparam int FlD = 3;
  localparam int FlB = 4;
  localparam int FlOne = 5;
  localparam int FlV = 6;
  localparam int FlN = 7;

  // classified request carried from front to back
  typedef struct packed {
    op_e         op;
    logic [7:0]  operand;
    logic [15:0] address;
    logic [7:0]  disp;
  } req_t;

  localparam int ReqW = $bits(req_t);

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [15:0] pc;
    logic        we;
    logic [15:0] waddr;
    logic [7:0]  wdata;
  } res_t;

endpackage

### sv/c6502_front.sv
`timescale 1ns / 1ps
module c6502_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [5:0]         op_i,
  input  logic [7:0]         operand_i,
  input  logic [15:0]        address_i,
  input  logic [7:0]         disp_i,
  output logic               valid_o,
  input  logic               ready_i,
  output c6502_pkg::req_t    req_o
);
  // two-entry queue; out-of-range selectors are mapped to nop here
  c6502_pkg::req_t mem_q [2];
  logic rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  c6502_pkg::req_t req_w;
  logic push, pop;

  always_comb begin
    req_w.op      = (op_i > 6'd51) ? c6502_pkg::OP_NOP : c6502_pkg::op_e'(op_i);
    req_w.operand = operand_i;
    req_w.address = address_i;
    req_w.disp    = disp_i;
  end

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign push = valid_i && ready_o;
  assign pop = valid_o && ready_i;
  assign req_o = mem_q[rd_q];
  assign rd_d = pop ? ~rd_q : rd_q;
  assign wr_d = push ? ~wr_q : wr_q;
  assign cnt_d = 2'(cnt_q + {1'b0, push} - {1'b0, pop});

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= req_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q <= rd_d;
      wr_q <= wr_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

### sv/c6502_back.sv
`timescale 1ns / 1ps
module c6502_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  c6502_pkg::req_t    req_i,
  output logic               valid_o,
  input  logic               ready_i,
  output c6502_pkg::res_t    res_o
);
  logic [7:0] a_q, a_d, x_q, x_d, y_q, y_d, s_q, s_d, p_q, p_d;
  logic [15:0] pc_q, pc_d;
  logic out_v_q;
  c6502_pkg::res_t res_q, res_d;
  logic fire;
  logic [7:0] m, addend, nz;
  logic [8:0] sum, cmpd;
  logic take, setnz;
  logic [7:0] cmpreg;

  assign ready_o = !out_v_q || ready_i;
  assign fire = valid_i && ready_o;
  assign m = req_i.operand;

  always_comb begin
    a_d = a_q; x_d = x_q; y_d = y_q; s_d = s_q; p_d = p_q; pc_d = pc_q;
    res_d.we = 1'b0; res_d.waddr = 16'd0; res_d.wdata = 8'd0;
    setnz = 1'b0; nz = 8'd0; take = 1'b0;
    addend = (req_i.op == c6502_pkg::OP_SBC) ? ~m : m;
    sum = {1'b0, a_q} + {1'b0, addend} + {8'd0, p_q[c6502_pkg::FlC]};
    unique case (req_i.op)
      c6502_pkg::OP_CPX: cmpreg = x_q;
      c6502_pkg::OP_CPY: cmpreg = y_q;
      default:           cmpreg = a_q;
    endcase
    cmpd = {1'b0, cmpreg} - {1'b0, m};
    unique case (req_i.op)
      c6502_pkg::OP_LDA, c6502_pkg::OP_PLA: begin
        a_d = m; setnz = 1'b1; nz = m;
        if (req_i.op == c6502_pkg::OP_PLA) s_d = s_q + 8'd1;
      end
      c6502_pkg::OP_LDX: begin x_d = m; setnz = 1'b1; nz = m; end
      c6502_pkg::OP_LDY: begin y_d = m; setnz = 1'b1; nz = m; end
      c6502_pkg::OP_STA: begin res_d.we = 1'b1; res_d.waddr = req_i.address; res_d.wdata = a_q; end
      c6502_pkg::OP_STX: begin res_d.we = 1'b1; res_d.waddr = req_i.address; res_d.wdata = x_q; end
      c6502_pkg::OP_STY: begin res_d.we = 1'b1; res_d.waddr = req_i.address; res_d.wdata = y_q; end
      c6502_pkg::OP_TAX: begin x_d = a_q; setnz = 1'b1; nz = a_q; end
      c6502_pkg::OP_TAY: begin y_d = a_q; setnz = 1'b1; nz = a_q; end
      c6502_pkg::OP_TXA: begin a_d = x_q; setnz = 1'b1; nz = x_q; end
      c6502_pkg::OP_TYA: begin a_d = y_q; setnz = 1'b1; nz = y_q; end
      c6502_pkg::OP_TSX: begin x_d = s_q; setnz = 1'b1; nz = s_q; end
      c6502_pkg::OP_TXS: s_d = x_q;
      c6502_pkg::OP_PHA, c6502_pkg::OP_PHP: begin
        res_d.we = 1'b1;
        res_d.waddr = {c6502_pkg::StackPage, s_q};
        res_d.wdata = (req_i.op == c6502_pkg::OP_PHA) ? a_q : (p_q | 8'h30);
        s_d = s_q - 8'd1;
      end
      c6502_pkg::OP_PLP: begin
        s_d = s_q + 8'd1;
        p_d = (m & 8'hEF) | (p_q & 8'h10) | 8'h20;
      end
      c6502_pkg::OP_AND: begin a_d = a_q & m; setnz = 1'b1; nz = a_q & m; end
      c6502_pkg::OP_EOR: begin a_d = a_q ^ m; setnz = 1'b1; nz = a_q ^ m; end
      c6502_pkg::OP_ORA: begin a_d = a_q | m; setnz = 1'b1; nz = a_q | m; end
      c6502_pkg::OP_BIT: begin
        p_d[c6502_pkg::FlN] = m[7];
        p_d[c6502_pkg::FlV] = m[6];
        p_d[c6502_pkg::FlZ] = ((a_q & m) == 8'd0);
      end
      c6502_pkg::OP_ADC, c6502_pkg::OP_SBC: begin
        a_d = sum[7:0]; setnz = 1'b1; nz = sum[7:0];
        p_d[c6502_pkg::FlC] = sum[8];
        p_d[c6502_pkg::FlV] = (a_q[7] ^ sum[7]) & (addend[7] ^ sum[7]);
      end
      c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY: begin
        p_d[c6502_pkg::FlC] = ~cmpd[8]; setnz = 1'b1; nz = cmpd[7:0];
      end
      c6502_pkg::OP_INC, c6502_pkg::OP_DEC: begin
        res_d.we = 1'b1; res_d.waddr = req_i.address;
        res_d.wdata = (req_i.op == c6502_pkg::OP_INC) ? m + 8'd1 : m - 8'd1;
        setnz = 1'b1; nz = res_d.wdata;
      end
      c6502_pkg::OP_INX: begin x_d = x_q + 8'd1; setnz = 1'b1; nz = x_d; end
      c6502_pkg::OP_INY: begin y_d = y_q + 8'd1; setnz = 1'b1; nz = y_d; end
      c6502_pkg::OP_DEX: begin x_d = x_q - 8'd1; setnz = 1'b1; nz = x_d; end
      c6502_pkg::OP_DEY: begin y_d = y_q - 8'd1; setnz = 1'b1; nz = y_d; end
      c6502_pkg::OP_ASL, c6502_pkg::OP_ROL: begin
        a_d = {a_q[6:0], (req_i.op == c6502_pkg::OP_ROL) & p_q[c6502_pkg::FlC]};
        p_d[c6502_pkg::FlC] = a_q[7]; setnz = 1'b1; nz = a_d;
      end
      c6502_pkg::OP_LSR, c6502_pkg::OP_ROR: begin
        a_d = {(req_i.op == c6502_pkg::OP_ROR) & p_q[c6502_pkg::FlC], a_q[7:1]};
        p_d[c6502_pkg::FlC] = a_q[0]; setnz = 1'b1; nz = a_d;
      end
      c6502_pkg::OP_JMP: pc_d = req_i.address;
      c6502_pkg::OP_BCC: take = !p_q[c6502_pkg::FlC];
      c6502_pkg::OP_BCS: take = p_q[c6502_pkg::FlC];
      c6502_pkg::OP_BEQ: take = p_q[c6502_pkg::FlZ];
      c6502_pkg::OP_BMI: take = p_q[c6502_pkg::FlN];
      c6502_pkg::OP_BNE: take = !p_q[c6502_pkg::FlZ];
      c6502_pkg::OP_BPL: take = !p_q[c6502_pkg::FlN];
      c6502_pkg::OP_BVC: take = !p_q[c6502_pkg::FlV];
      c6502_pkg::OP_BVS: take = p_q[c6502_pkg::FlV];
      c6502_pkg::OP_CLC: p_d[c6502_pkg::FlC] = 1'b0;
      c6502_pkg::OP_CLD: p_d[c6502_pkg::FlD] = 1'b0;
      c6502_pkg::OP_CLI: p_d[c6502_pkg::FlI] = 1'b0;
      c6502_pkg::OP_CLV: p_d[c6502_pkg::FlV] = 1'b0;
      c6502_pkg::OP_SEC: p_d[c6502_pkg::FlC] = 1'b1;
      c6502_pkg::OP_SED: p_d[c6502_pkg::FlD] = 1'b1;
      c6502_pkg::OP_SEI: p_d[c6502_pkg::FlI] = 1'b1;
      default: ;
    endcase
    if (take) pc_d = pc_q + {{8{req_i.disp[7]}}, req_i.disp};
    if (setnz) begin
      p_d[c6502_pkg::FlZ] = (nz == 8'd0);
      p_d[c6502_pkg::FlN] = nz[7];
    end
    res_d.acc = a_d; res_d.x = x_d; res_d.y = y_d;
    res_d.sp = s_d; res_d.p = p_d; res_d.pc = pc_d;
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0;
      s_q <= c6502_pkg::ResetSp; p_q <= c6502_pkg::ResetP; pc_q <= 16'd0;
      out_v_q <= 1'b0;
    end else begin
      if (fire) begin
        a_q <= a_d; x_q <= x_d; y_q <= y_d; s_q <= s_d; p_q <= p_d; pc_q <= pc_d;
      end
      if (fire) out_v_q <= 1'b1;
      else if (ready_i) out_v_q <= 1'b0;
    end
  end

  assign valid_o = out_v_q;
  assign res_o = res_q;
endmodule

### sv/cpu6502_execute_unit.sv
`timescale 1ns / 1ps
// execute unit of a 6502-style cpu holding a, x, y, s, p and pc. one request
// per cycle sustained while the output is not stalled: a front queue (two
// entries) takes and classifies requests, the back stage executes one per
// cycle against the architectural registers and holds the result in an
// output register, so a request is taken as a waiting result is accepted.
// decimal mode is stored only; selectors above nop act as nop.
module cpu6502_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[5:0], operand[13:6], address[29:14], displacement[37:30], pad
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // acc_out[7:0], x_out[15:8], y_out[23:16], sp_out[31:24], flags_out[39:32],
  // pc_out[55:40], write_enable[56], write_address[72:57], write_data[80:73], pad
  output logic [87:0] m_axis_tdata
);
  c6502_pkg::req_t q_req;
  c6502_pkg::res_t res;
  logic q_valid, q_ready;

  c6502_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .op_i(s_axis_tdata[5:0]), .operand_i(s_axis_tdata[13:6]),
    .address_i(s_axis_tdata[29:14]), .disp_i(s_axis_tdata[37:30]),
    .valid_o(q_valid), .ready_i(q_ready), .req_o(q_req)
  );

  c6502_back u_back (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .ready_o(q_ready), .req_i(q_req),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {7'd0, res.wdata, res.waddr, res.we, res.pc, res.p,
                         res.sp, res.y, res.x, res.acc};

  // status bit 5 always reads as one in any delivered result
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[37]) else $error("flag bit 5 clear");
  // no write means zero address and data
  a_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[56]) |-> (m_axis_tdata[80:57] == 24'd0))
    else $error("stale write fields");
  // result stays while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
endmodule
